### sv/xml_tag_stream_parser_defines.svh
// Assertion macros shared by the XML tag stream parser RTL.
`ifndef XML_TAG_STREAM_PARSER_DEFINES_SVH
`define XML_TAG_STREAM_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define XTSP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("xtsp assertion failed");
`define XTSP_NEVER(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("xtsp forbidden condition seen");
`else
`define XTSP_ASSERT(lbl, clk, rst_n, prop)
`define XTSP_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

### sv/xtsp_pkg.sv
// Package with types and constants of the XML tag stream parser.
`timescale 1ns / 1ps
package xtsp_pkg;
    localparam int unsigned DEF_MAX_DEPTH = 10;
    localparam int unsigned DEF_NAME_MAX  = 64;
    localparam int unsigned DEF_VALUE_MAX = 510;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUEST = 8'h3F;

    typedef enum logic [2:0] {
        K_NAME    = 3'd0,
        K_VALUE   = 3'd1,
        K_VEND    = 3'd2,
        K_DISCARD = 3'd3,
        K_OPEN    = 3'd4,
        K_DOC_OK  = 3'd5,
        K_ERROR   = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE      = 3'd0,
        E_NAME_LONG = 3'd1,
        E_VALUE_LONG = 3'd2,
        E_TOO_DEEP  = 3'd3,
        E_MISMATCH  = 3'd4,
        E_UNCLOSED  = 3'd5
    } t_err;

    typedef enum logic [8:0] {
        M_OUTSIDE    = 9'b000000001,
        M_AFTER_LT   = 9'b000000010,
        M_TAG_HEAD   = 9'b000000100,
        M_COMMENT    = 9'b000001000,
        M_INSTR      = 9'b000010000,
        M_CONTENT    = 9'b000100000,
        M_CONTENT_LT = 9'b001000000,
        M_CLOSE      = 9'b010000000,
        M_ERROR      = 9'b100000000
    } t_mode;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic [3:0] depth;
        t_err       error_code;
    } t_result;
endpackage

### sv/xtsp_ifs.sv
// Stream interfaces for document bytes in and parse results out.
`timescale 1ns / 1ps
interface xtsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface xtsp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [3:0] depth;
    logic [2:0] error_code;
    modport source (output valid, output kind, output out_byte, output depth,
                    output error_code, input ready);
    modport sink (input valid, input kind, input out_byte, input depth,
                  input error_code, output ready);
endinterface

### sv/xml_tag_stream_parser.sv
// Top level of the XML tag stream parser.
// Throughput: one document byte per cycle, sustained, while results drain.
// A result is pushed into the output queue as its byte is accepted.
// Close-tag reads of the name store are registered; the compare is forwarded.
// Reset clears mode, depth and counters; the name store is never cleared.
`timescale 1ns / 1ps
module xml_tag_stream_parser import xtsp_pkg::*; #(
    parameter int unsigned MAX_DEPTH = DEF_MAX_DEPTH,
    parameter int unsigned NAME_MAX  = DEF_NAME_MAX,
    parameter int unsigned VALUE_MAX = DEF_VALUE_MAX
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    xtsp_in_if.sink   i_in,
    xtsp_out_if.source o_out
);
    localparam int unsigned SLOTS = MAX_DEPTH + 1;
    localparam int unsigned DEPTH = SLOTS * NAME_MAX;
    localparam int unsigned AW    = $clog2(DEPTH);

    logic          accept, not_full, res_valid;
    t_result       res, q_data;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    assign i_in.ready = not_full;
    assign accept     = i_in.valid && not_full;

    xtsp_ctrl #(
        .MAX_DEPTH(MAX_DEPTH), .NAME_MAX(NAME_MAX), .VALUE_MAX(VALUE_MAX),
        .SLOTS(SLOTS), .AW(AW)
    ) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept),
        .i_data_byte(i_in.data_byte), .i_last_byte(i_in.last_byte),
        .o_res_valid(res_valid), .o_res(res),
        .o_wr_en(wr_en), .o_wr_addr(wr_addr), .o_wr_data(wr_data),
        .o_rd_en(rd_en), .o_rd_addr(rd_addr), .i_rd_data(rd_data)
    );

    xtsp_name_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_wr_en(wr_en), .i_wr_addr(wr_addr), .i_wr_data(wr_data),
        .i_rd_en(rd_en), .i_rd_addr(rd_addr), .o_rd_data(rd_data)
    );

    xtsp_outq u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(res_valid), .i_data(res),
        .o_not_full(not_full), .o_valid(o_out.valid), .o_data(q_data),
        .i_ready(o_out.ready)
    );

    assign o_out.kind       = q_data.kind;
    assign o_out.out_byte   = q_data.out_byte;
    assign o_out.depth      = q_data.depth;
    assign o_out.error_code = q_data.error_code;
endmodule

### sv/xtsp_name_mem.sv
// Name store memory: one write port, one registered read port.
`timescale 1ns / 1ps
module xtsp_name_mem import xtsp_pkg::*; #(
    parameter int unsigned DEPTH = (DEF_MAX_DEPTH + 1) * DEF_NAME_MAX,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

### sv/xtsp_outq.sv
// Two-entry result queue between the parser and the output channel.
`timescale 1ns / 1ps
`include "xml_tag_stream_parser_defines.svh"
module xtsp_outq import xtsp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_not_full,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);
    t_result    r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_not_full = (r_cnt != 2'd2);
    assign o_data     = r_ent[r_rp];
    assign pop        = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_data;
        end
    end

    `XTSP_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && r_cnt == 2'd2 && !pop)
    `XTSP_NEVER(a_no_underflow, i_clk, i_rst_n, pop && r_cnt == 2'd0)
    `XTSP_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= 2'd2)
endmodule

### sv/xtsp_ctrl.sv
// Parse control: mode tracking, name store access and result generation.
`timescale 1ns / 1ps
`include "xml_tag_stream_parser_defines.svh"
module xtsp_ctrl import xtsp_pkg::*; #(
    parameter int unsigned MAX_DEPTH = DEF_MAX_DEPTH,
    parameter int unsigned NAME_MAX  = DEF_NAME_MAX,
    parameter int unsigned VALUE_MAX = DEF_VALUE_MAX,
    parameter int unsigned SLOTS     = MAX_DEPTH + 1,
    parameter int unsigned AW        = $clog2(SLOTS * NAME_MAX)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    output logic          o_res_valid,
    output t_result       o_res,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  logic [7:0]    i_rd_data
);
    localparam int unsigned DW = $clog2(SLOTS + 1);
    localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned IW = $clog2(NAME_MAX);
    localparam int unsigned VW = $clog2(VALUE_MAX + 1);

    t_mode          r_mode, n_mode, p_mode;
    logic [DW-1:0]  r_depth, n_depth, p_depth, base_depth;
    logic [IW-1:0]  r_idx, n_idx, p_idx;
    logic [VW-1:0]  r_vc, n_vc, p_vc;
    logic           r_mism, n_mism, p_mism, eff_mism;
    logic [1:0]     r_tm, n_tm, p_tm;
    logic [IW-1:0]  r_len [SLOTS];
    logic           r_pb_valid, n_pb_valid;
    logic           r_pb_oob;
    logic [7:0]     r_pb_byte;

    logic [7:0]     b;
    logic           was_err, do_proc, rd_req, wr_req, len_we;
    logic [SW-1:0]  slot, cslot;
    logic [AW-1:0]  slot_base, close_addr, wr_addr;
    logic           close_oob;
    logic           res_v;
    t_kind          res_kind;
    logic [7:0]     res_byte;
    t_err           res_err;
    logic [DW+3:0]  depth_ext;

    assign b       = i_data_byte;
    assign was_err = (r_mode == M_ERROR);
    assign do_proc = (b != CH_NUL) && !was_err;
    assign slot    = (r_depth < DW'(SLOTS)) ? r_depth[SW-1:0] : SW'(SLOTS - 1);
    assign cslot   = SW'(r_depth - DW'(1));
    assign slot_base  = AW'(slot) * AW'(NAME_MAX);
    assign close_addr = AW'(cslot) * AW'(NAME_MAX) + AW'(r_idx);
    assign close_oob  = (r_idx >= r_len[cslot]);

    // The compare for the previous close-tag byte resolves this cycle.
    assign eff_mism = r_mism || (r_pb_valid && (r_pb_oob || (i_rd_data != r_pb_byte)));

    always_comb begin
        p_mode   = r_mode;
        p_depth  = r_depth;
        p_idx    = r_idx;
        p_vc     = r_vc;
        p_mism   = eff_mism;
        p_tm     = r_tm;
        res_v    = 1'b0;
        res_kind = K_NAME;
        res_byte = 8'h00;
        res_err  = E_NONE;
        wr_req   = 1'b0;
        wr_addr  = slot_base + AW'(r_idx);
        rd_req   = 1'b0;
        len_we   = 1'b0;
        unique case (r_mode)
            M_OUTSIDE: begin
                if (b == CH_LT) begin
                    p_mode = M_AFTER_LT;
                end
            end
            M_AFTER_LT, M_CONTENT_LT: begin
                if (r_mode == M_CONTENT_LT && b == CH_SLASH) begin
                    p_mode   = M_CLOSE;
                    p_idx    = '0;
                    p_mism   = 1'b0;
                    res_v    = 1'b1;
                    res_kind = K_VEND;
                end else if (b == CH_BANG || b == CH_QUEST) begin
                    p_mode = (b == CH_BANG) ? M_COMMENT : M_INSTR;
                    p_idx  = '0;
                    p_tm   = 2'd0;
                end else if (r_mode == M_CONTENT_LT && r_depth >= DW'(SLOTS)) begin
                    p_mode   = M_ERROR;
                    res_v    = 1'b1;
                    res_kind = K_ERROR;
                    res_err  = E_TOO_DEEP;
                end else begin
                    wr_req   = 1'b1;
                    wr_addr  = slot_base;
                    p_idx    = IW'(1);
                    p_mode   = M_TAG_HEAD;
                    res_v    = 1'b1;
                    res_kind = (r_mode == M_AFTER_LT) ? K_NAME : K_DISCARD;
                    res_byte = b;
                end
            end
            M_TAG_HEAD: begin
                if (b == CH_GT) begin
                    len_we   = 1'b1;
                    p_depth  = DW'(slot) + DW'(1);
                    p_vc     = '0;
                    p_mode   = M_CONTENT;
                    res_v    = 1'b1;
                    res_kind = K_OPEN;
                end else if (r_idx >= IW'(NAME_MAX - 2)) begin
                    p_mode   = M_ERROR;
                    res_v    = 1'b1;
                    res_kind = K_ERROR;
                    res_err  = E_NAME_LONG;
                end else begin
                    wr_req   = 1'b1;
                    p_idx    = r_idx + IW'(1);
                    res_v    = 1'b1;
                    res_byte = b;
                end
            end
            M_COMMENT: begin
                if (b == CH_GT && r_tm == 2'd2 && r_idx >= IW'(3)) begin
                    p_mode = (r_depth != '0) ? M_CONTENT : M_OUTSIDE;
                end else begin
                    p_tm = (b == CH_DASH) ? ((r_tm < 2'd2) ? r_tm + 2'd1 : 2'd2) : 2'd0;
                    if (r_idx < IW'(3)) begin
                        p_idx = r_idx + IW'(1);
                    end
                end
            end
            M_INSTR: begin
                if (b == CH_GT && r_tm == 2'd1) begin
                    p_mode = (r_depth != '0) ? M_CONTENT : M_OUTSIDE;
                end else begin
                    p_tm = (b == CH_QUEST) ? 2'd1 : 2'd0;
                end
            end
            M_CONTENT: begin
                if (b == CH_SPACE) begin
                    p_mode = M_CONTENT;
                end else if (b == CH_LT) begin
                    p_mode = M_CONTENT_LT;
                end else if (r_vc >= VW'(VALUE_MAX)) begin
                    p_mode   = M_ERROR;
                    res_v    = 1'b1;
                    res_kind = K_ERROR;
                    res_err  = E_VALUE_LONG;
                end else begin
                    p_vc     = r_vc + VW'(1);
                    res_v    = 1'b1;
                    res_kind = K_VALUE;
                    res_byte = b;
                end
            end
            M_CLOSE: begin
                if (r_depth == '0) begin
                    p_mode   = M_ERROR;
                    res_v    = 1'b1;
                    res_kind = K_ERROR;
                    res_err  = E_MISMATCH;
                end else if (b == CH_GT) begin
                    if (eff_mism || r_idx != r_len[cslot]) begin
                        p_mode   = M_ERROR;
                        res_v    = 1'b1;
                        res_kind = K_ERROR;
                        res_err  = E_MISMATCH;
                    end else begin
                        p_depth = DW'(cslot);
                        p_vc    = '0;
                        p_mode  = (cslot != '0) ? M_CONTENT : M_OUTSIDE;
                    end
                end else begin
                    rd_req = 1'b1;
                    if (r_idx < IW'(NAME_MAX - 1)) begin
                        p_idx = r_idx + IW'(1);
                    end
                end
            end
            default: begin
                p_mode = M_ERROR;
            end
        endcase
    end

    // Document end and clearing wrap around the per-byte update.
    always_comb begin
        n_mode      = do_proc ? p_mode : r_mode;
        n_depth     = do_proc ? p_depth : r_depth;
        n_idx       = do_proc ? p_idx : r_idx;
        n_vc        = do_proc ? p_vc : r_vc;
        n_mism      = do_proc ? p_mism : eff_mism;
        n_tm        = do_proc ? p_tm : r_tm;
        base_depth  = n_depth;
        o_res_valid = i_accept && do_proc && res_v;
        o_res.kind  = res_kind;
        o_res.out_byte   = res_byte;
        o_res.error_code = res_err;
        n_pb_valid  = do_proc && rd_req;
        if ((b == CH_NUL && !was_err) || (do_proc && i_last_byte && p_mode != M_ERROR)) begin
            o_res_valid      = i_accept;
            o_res.kind       = (base_depth != '0) ? K_ERROR : K_DOC_OK;
            o_res.out_byte   = 8'h00;
            o_res.error_code = (base_depth != '0) ? E_UNCLOSED : E_NONE;
            n_mode = M_OUTSIDE;
        end else if (b == CH_NUL || i_last_byte) begin
            n_mode = M_OUTSIDE;
        end
        if (n_mode == M_OUTSIDE && (b == CH_NUL || i_last_byte)) begin
            n_depth    = '0;
            n_idx      = '0;
            n_vc       = '0;
            n_mism     = 1'b0;
            n_tm       = 2'd0;
            n_pb_valid = 1'b0;
        end
        if (was_err && b != CH_NUL && !i_last_byte) begin
            n_mode = M_ERROR;
        end
        depth_ext   = {4'b0000, base_depth};
        o_res.depth = depth_ext[3:0];
    end

    assign o_wr_en   = i_accept && do_proc && wr_req;
    assign o_wr_addr = wr_addr;
    assign o_wr_data = b;
    assign o_rd_en   = i_accept && do_proc && rd_req;
    assign o_rd_addr = close_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_OUTSIDE;
            r_depth    <= '0;
            r_idx      <= '0;
            r_vc       <= '0;
            r_mism     <= 1'b0;
            r_tm       <= 2'd0;
            r_pb_valid <= 1'b0;
        end else if (i_accept) begin
            r_mode     <= n_mode;
            r_depth    <= n_depth;
            r_idx      <= n_idx;
            r_vc       <= n_vc;
            r_mism     <= n_mism;
            r_tm       <= n_tm;
            r_pb_valid <= n_pb_valid;
        end else begin
            r_mism     <= eff_mism;
            r_pb_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pb_oob  <= close_oob;
            r_pb_byte <= b;
        end
        if (i_accept && do_proc && len_we) begin
            r_len[slot] <= r_idx;
        end
    end

    `XTSP_ASSERT(a_depth_bound, i_clk, i_rst_n, r_depth <= DW'(SLOTS))
    `XTSP_ASSERT(a_pend_in_close, i_clk, i_rst_n, r_pb_valid |-> r_mode == M_CLOSE)
    `XTSP_ASSERT(a_err_silent, i_clk, i_rst_n, (i_accept && was_err && b != CH_NUL) |-> !o_res_valid)
endmodule

### test/xml_tag_stream_parser_test.sv
// Self-checking testbench for the XML tag stream parser.
`timescale 1ns / 1ps
module xml_tag_stream_parser_test;
    import xtsp_pkg::*;

    localparam int SLOTS = DEF_MAX_DEPTH + 1;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         typed;
        t_result    res;
    } t_stim;

    localparam t_result NO_RES = '{K_NAME, 8'h00, 4'd0, E_NONE};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    xtsp_in_if  in_bus();
    xtsp_out_if out_bus();

    xml_tag_stream_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus.sink),
        .o_out   (out_bus.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_stim   byte_stream[$];
    t_result expected_results[$];
    int      send_idx = 0;
    int      idle_cycles = 0;
    bit      failed = 0;

    // Directed rows: a small element, comment and instruction corner cases, an unclosed end on a
    // final byte, and a close mismatch. Rows with typed set carry their result.
    t_stim directed_rows[$] = '{
        '{CH_LT,    1'b0, 1'b0, NO_RES},
        '{8'h61,    1'b0, 1'b1, '{K_NAME, 8'h61, 4'd0, E_NONE}},
        '{CH_GT,    1'b0, 1'b1, '{K_OPEN, 8'h00, 4'd1, E_NONE}},
        '{8'hFF,    1'b0, 1'b1, '{K_VALUE, 8'hFF, 4'd1, E_NONE}},
        '{CH_SPACE, 1'b0, 1'b0, NO_RES},
        '{CH_LT,    1'b0, 1'b0, NO_RES},
        '{CH_SLASH, 1'b0, 1'b1, '{K_VEND, 8'h00, 4'd1, E_NONE}},
        '{8'h61,    1'b0, 1'b0, NO_RES},
        '{CH_GT,    1'b0, 1'b0, NO_RES},
        '{CH_NUL,   1'b0, 1'b1, '{K_DOC_OK, 8'h00, 4'd0, E_NONE}},
        '{CH_LT,    1'b0, 1'b0, NO_RES},
        '{CH_BANG,  1'b0, 1'b0, NO_RES},
        '{CH_DASH,  1'b0, 1'b0, NO_RES},
        '{CH_DASH,  1'b0, 1'b0, NO_RES},
        '{CH_GT,    1'b0, 1'b0, NO_RES},
        '{CH_DASH,  1'b0, 1'b0, NO_RES},
        '{CH_DASH,  1'b0, 1'b0, NO_RES},
        '{CH_GT,    1'b0, 1'b0, NO_RES},
        '{CH_LT,    1'b0, 1'b0, NO_RES},
        '{CH_QUEST, 1'b0, 1'b0, NO_RES},
        '{CH_QUEST, 1'b0, 1'b0, NO_RES},
        '{CH_GT,    1'b0, 1'b0, NO_RES},
        '{CH_LT,    1'b0, 1'b0, NO_RES},
        '{8'h01,    1'b0, 1'b1, '{K_NAME, 8'h01, 4'd0, E_NONE}},
        '{CH_GT,    1'b1, 1'b1, '{K_ERROR, 8'h00, 4'd1, E_UNCLOSED}},
        '{CH_LT,    1'b0, 1'b0, NO_RES},
        '{8'h80,    1'b0, 1'b0, NO_RES},
        '{CH_GT,    1'b0, 1'b0, NO_RES},
        '{CH_LT,    1'b0, 1'b0, NO_RES},
        '{CH_SLASH, 1'b0, 1'b0, NO_RES},
        '{8'h7F,    1'b0, 1'b0, NO_RES},
        '{CH_GT,    1'b0, 1'b1, '{K_ERROR, 8'h00, 4'd1, E_MISMATCH}},
        '{CH_NUL,   1'b1, 1'b0, NO_RES}
    };

    // Shadow of the parser state.
    t_mode      mode;
    logic [7:0] names[SLOTS][DEF_NAME_MAX];
    int         name_len[SLOTS];
    int         nest;
    int         bidx;
    int         vcount;
    bit         mism;
    int         term;

    function automatic t_result make_res(t_kind k, logic [7:0] b, t_err e);
        t_result r;
        r.kind = k;
        r.out_byte = b;
        r.depth = nest[3:0];
        r.error_code = e;
        return r;
    endfunction

    function automatic void clear_doc();
        mode = M_OUTSIDE;
        nest = 0;
        bidx = 0;
        vcount = 0;
        mism = 0;
        term = 0;
    endfunction

    function automatic void begin_aside(logic [7:0] b);
        mode = (b == CH_BANG) ? M_COMMENT : M_INSTR;
        bidx = 0;
        term = 0;
    endfunction

    function automatic void begin_name(logic [7:0] b);
        int slot;
        slot = nest < SLOTS ? nest : SLOTS - 1;
        names[slot][0] = b;
        bidx = 1;
        mode = M_TAG_HEAD;
    endfunction

    // Advances the shadow state by one byte; got is set when a result comes out.
    function automatic void parse_byte(logic [7:0] b, output bit got, output t_result r);
        int slot;
        got = 0;
        r = make_res(K_NAME, 8'h00, E_NONE);
        case (mode)
            M_OUTSIDE: begin
                if (b == CH_LT) mode = M_AFTER_LT;
            end
            M_AFTER_LT: begin
                if (b == CH_BANG || b == CH_QUEST) begin
                    begin_aside(b);
                end else begin
                    begin_name(b);
                    got = 1; r = make_res(K_NAME, b, E_NONE);
                end
            end
            M_TAG_HEAD: begin
                slot = nest < SLOTS ? nest : SLOTS - 1;
                if (b == CH_GT) begin
                    name_len[slot] = bidx;
                    nest = slot + 1;
                    vcount = 0;
                    mode = M_CONTENT;
                    got = 1; r = make_res(K_OPEN, 8'h00, E_NONE);
                end else if (bidx >= DEF_NAME_MAX - 2) begin
                    mode = M_ERROR;
                    got = 1; r = make_res(K_ERROR, 8'h00, E_NAME_LONG);
                end else begin
                    names[slot][bidx] = b;
                    bidx++;
                    got = 1; r = make_res(K_NAME, b, E_NONE);
                end
            end
            M_COMMENT: begin
                if (b == CH_GT && term == 2 && bidx >= 3) begin
                    mode = nest != 0 ? M_CONTENT : M_OUTSIDE;
                end else begin
                    term = (b == CH_DASH) ? (term < 2 ? term + 1 : 2) : 0;
                    if (bidx < 3) bidx++;
                end
            end
            M_INSTR: begin
                if (b == CH_GT && term == 1) mode = nest != 0 ? M_CONTENT : M_OUTSIDE;
                else term = (b == CH_QUEST) ? 1 : 0;
            end
            M_CONTENT: begin
                if (b == CH_LT) begin
                    mode = M_CONTENT_LT;
                end else if (b != CH_SPACE) begin
                    if (vcount >= DEF_VALUE_MAX) begin
                        mode = M_ERROR;
                        got = 1; r = make_res(K_ERROR, 8'h00, E_VALUE_LONG);
                    end else begin
                        vcount++;
                        got = 1; r = make_res(K_VALUE, b, E_NONE);
                    end
                end
            end
            M_CONTENT_LT: begin
                if (b == CH_SLASH) begin
                    mode = M_CLOSE;
                    bidx = 0;
                    mism = 0;
                    got = 1; r = make_res(K_VEND, 8'h00, E_NONE);
                end else if (b == CH_BANG || b == CH_QUEST) begin
                    begin_aside(b);
                end else if (nest >= SLOTS) begin
                    mode = M_ERROR;
                    got = 1; r = make_res(K_ERROR, 8'h00, E_TOO_DEEP);
                end else begin
                    begin_name(b);
                    got = 1; r = make_res(K_DISCARD, b, E_NONE);
                end
            end
            M_CLOSE: begin
                if (nest == 0 || nest > SLOTS) begin
                    mode = M_ERROR;
                    got = 1; r = make_res(K_ERROR, 8'h00, E_MISMATCH);
                end else begin
                    slot = nest - 1;
                    if (b == CH_GT) begin
                        if (mism || bidx != name_len[slot]) begin
                            mode = M_ERROR;
                            got = 1; r = make_res(K_ERROR, 8'h00, E_MISMATCH);
                        end else begin
                            nest = slot;
                            vcount = 0;
                            mode = nest != 0 ? M_CONTENT : M_OUTSIDE;
                        end
                    end else begin
                        if (bidx >= name_len[slot] || bidx >= DEF_NAME_MAX ||
                                names[slot][bidx] != b)
                            mism = 1;
                        if (bidx < DEF_NAME_MAX - 1) bidx++;
                    end
                end
            end
            default: mode = M_ERROR;
        endcase
    endfunction

    function automatic t_result end_document();
        t_result r;
        r = (nest != 0) ? make_res(K_ERROR, 8'h00, E_UNCLOSED)
                        : make_res(K_DOC_OK, 8'h00, E_NONE);
        clear_doc();
        return r;
    endfunction

    function automatic void predict_item(logic [7:0] b, logic last);
        bit      was_err;
        bit      got;
        t_result r;
        was_err = (mode == M_ERROR);
        if (b == CH_NUL) begin
            if (was_err) clear_doc();
            else expected_results.push_back(end_document());
        end else if (was_err) begin
            if (last) clear_doc();
        end else begin
            parse_byte(b, got, r);
            if (!last) begin
                if (got) expected_results.push_back(r);
            end else if (mode == M_ERROR) begin
                clear_doc();
                expected_results.push_back(r);
            end else begin
                expected_results.push_back(end_document());
            end
        end
    endfunction

    // Stimulus building.
    function automatic void put_byte(logic [7:0] b, logic last = 1'b0);
        t_stim s;
        s.data = b; s.last = last; s.typed = 0; s.res = NO_RES;
        byte_stream.push_back(s);
    endfunction

    function automatic logic [7:0] any_text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == CH_LT);
        return b;
    endfunction

    function automatic void put_name(ref logic [7:0] nm[$]);
        int n;
        logic [7:0] b;
        n = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 64) : $urandom_range(1, 6);
        nm.delete();
        for (int i = 0; i < n; i++) begin
            do b = 8'($urandom_range(1, 255));
            while (b == CH_GT || (i == 0 && (b == CH_BANG || b == CH_QUEST)));
            nm.push_back(b);
            put_byte(b);
        end
    endfunction

    function automatic void put_aside();
        if ($urandom_range(0, 1)) begin
            put_byte(CH_LT); put_byte(CH_BANG); put_byte(CH_DASH); put_byte(CH_DASH);
            repeat ($urandom_range(0, 4)) put_byte(8'(8'h61 + $urandom_range(0, 25)));
            put_byte(CH_DASH); put_byte(CH_DASH); put_byte(CH_GT);
        end else begin
            put_byte(CH_LT); put_byte(CH_QUEST);
            repeat ($urandom_range(0, 4)) put_byte(8'(8'h61 + $urandom_range(0, 25)));
            put_byte(CH_QUEST); put_byte(CH_GT);
        end
    endfunction

    function automatic void put_element(int level, int max_level);
        logic [7:0] nm[$];
        put_byte(CH_LT);
        put_name(nm);
        put_byte(CH_GT);
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 5))
                0, 1: repeat ($urandom_range(1, 6)) put_byte(any_text_byte());
                2: put_byte(CH_SPACE);
                3: put_aside();
                default: if (level < max_level) put_element(level + 1, max_level);
            endcase
        end
        if ($urandom_range(0, 39) == 0) repeat (DEF_VALUE_MAX + 2) put_byte(any_text_byte());
        put_byte(CH_LT); put_byte(CH_SLASH);
        foreach (nm[i]) begin
            if ($urandom_range(0, 59) == 0) put_byte(nm[i] ^ 8'h01);
            else put_byte(nm[i]);
        end
        if ($urandom_range(0, 29) == 0) put_byte(8'h7A);
        put_byte(CH_GT);
    endfunction

    function automatic void put_document();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            // Noise, including bytes that open tags at random.
            repeat ($urandom_range(1, 20)) put_byte(8'($urandom_range(1, 255)));
        end else begin
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put_byte(any_text_byte());
            if ($urandom_range(0, 4) == 0) put_aside();
            put_element(1, ($urandom_range(0, 7) == 0) ? 13 : 3);
            if (sel == 1) repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 2) == 0) byte_stream[$].last = 1'b1;
        else put_byte(CH_NUL, 1'($urandom_range(0, 1)));
    endfunction

    task automatic check_result(t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            $error("result with none expected: kind %0d", got.kind);
            failed = 1;
        end else begin
            want = expected_results.pop_front();
            if (got.kind != want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind); failed = 1;
            end
            if (got.out_byte != want.out_byte) begin
                $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
                failed = 1;
            end
            if (got.depth != want.depth) begin
                $error("depth: expected %0d, actual %0d", want.depth, got.depth); failed = 1;
            end
            if (got.error_code != want.error_code) begin
                $error("error_code: expected %0d, actual %0d", want.error_code,
                       got.error_code);
                failed = 1;
            end
        end
    endtask

    initial begin
        in_bus.valid = 1'b0;
        in_bus.data_byte = 8'h00;
        in_bus.last_byte = 1'b0;
        out_bus.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        int        send_idle;
        int        recv_stall;
        int        sz;
        bit        moved;
        t_result   got;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            out_bus.ready <= 1'b0;
            clear_doc();
        end else begin
            moved = 0;
            if (send_idx < byte_stream.size() / 3) begin
                send_idle = 34; recv_stall = 62;
            end else if (send_idx < 2 * byte_stream.size() / 3) begin
                send_idle = 62; recv_stall = 34;
            end else begin
                send_idle = 0; recv_stall = 0;
            end
            if (in_bus.valid && in_bus.ready) begin
                moved = 1;
                sz = expected_results.size();
                predict_item(in_bus.data_byte, in_bus.last_byte);
                if (byte_stream[send_idx - 1].typed) begin
                    if (expected_results.size() > sz) void'(expected_results.pop_back());
                    expected_results.push_back(byte_stream[send_idx - 1].res);
                end
            end
            if (out_bus.valid && out_bus.ready) begin
                moved = 1;
                got.kind = t_kind'(out_bus.kind);
                got.out_byte = out_bus.out_byte;
                got.depth = out_bus.depth;
                got.error_code = t_err'(out_bus.error_code);
                check_result(got);
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (!in_bus.valid || in_bus.ready) begin
                if (send_idx < byte_stream.size() && $urandom_range(0, 99) >= send_idle) begin
                    in_bus.valid <= 1'b1;
                    in_bus.data_byte <= byte_stream[send_idx].data;
                    in_bus.last_byte <= byte_stream[send_idx].last;
                    send_idx++;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
            out_bus.ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    initial begin
        foreach (directed_rows[i]) byte_stream.push_back(directed_rows[i]);

        while (byte_stream.size() < 820) put_document();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (send_idx < byte_stream.size() || in_bus.valid || expected_results.size() != 0)
        begin
            @(posedge i_clk);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("xml_tag_stream_parser_test NOT OK");
                $finish;
            end
        end
        repeat (10) @(posedge i_clk);
        if (!failed && expected_results.size() == 0) begin
            $display("xml_tag_stream_parser_test OK");
        end else begin
            $display("xml_tag_stream_parser_test NOT OK");
        end
        $finish;
    end
endmodule
